FILE: rtl/core/plm_pkg.sv
// Shared types and codes for the pump link activity monitor.
`default_nettype none

package plm_pkg;

	localparam int KIND_W  = 2;
	localparam int FIELD_W = 16;
	localparam int AGE_W   = 32;
	localparam int ST_W    = 3;
	localparam int WIN_W   = 8;
	localparam int LIM_W   = 20;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EVAL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

	localparam logic [ST_W-1:0] ST_OK             = 3'd1;
	localparam logic [ST_W-1:0] ST_RECENT         = 3'd2;
	localparam logic [ST_W-1:0] ST_NO_COMMS       = 3'd3;
	localparam logic [ST_W-1:0] ST_NO_COMMS_LONG  = 3'd4;
	localparam logic [ST_W-1:0] ST_ONE_IDLE       = 3'd5;
	localparam logic [ST_W-1:0] ST_BOTH_IDLE      = 3'd6;
	localparam logic [ST_W-1:0] ST_BOTH_IDLE_LONG = 3'd7;

	localparam logic [REG_IDX_W-1:0] REG_RECENT_WINDOW = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PUMP_IDLE     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PUMP_IDLE_LNG = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COMMS_LOST    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COMMS_LOST_LNG = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BOTH_HOLD     = 3'd5;

	localparam logic [WIN_W-1:0] RST_RECENT_WINDOW  = 8'd10;
	localparam logic [LIM_W-1:0] RST_PUMP_IDLE      = 20'd14400;
	localparam logic [LIM_W-1:0] RST_PUMP_IDLE_LNG  = 20'd28800;
	localparam logic [LIM_W-1:0] RST_COMMS_LOST     = 20'd900;
	localparam logic [LIM_W-1:0] RST_COMMS_LOST_LNG = 20'd3600;
	localparam logic [LIM_W-1:0] RST_BOTH_HOLD      = 20'd3600;

	typedef struct packed {
		logic [WIN_W-1:0] recent_window_s;
		logic [LIM_W-1:0] pump_idle_s;
		logic [LIM_W-1:0] pump_idle_long_s;
		logic [LIM_W-1:0] comms_lost_s;
		logic [LIM_W-1:0] comms_lost_long_s;
		logic [LIM_W-1:0] both_change_hold_s;
	} plm_cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FIELD_W-1:0] report_seq;
		logic [FIELD_W-1:0] report_pump1;
		logic [FIELD_W-1:0] report_pump2;
		logic               crc_match;
	} plm_item_t;

	typedef struct packed {
		logic [ST_W-1:0]    status;
		logic [AGE_W-1:0]   seq_age_s;
		logic [AGE_W-1:0]   pump1_age_s;
		logic [AGE_W-1:0]   pump2_age_s;
		logic [FIELD_W-1:0] held_seq;
		logic [FIELD_W-1:0] held_pump1;
		logic [FIELD_W-1:0] held_pump2;
		logic               both_changed_recent;
	} plm_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/plm_item_if.sv
// Input channel interface: tick, evaluate and report words.
`default_nettype none

interface plm_item_if
	import plm_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [FIELD_W-1:0] report_seq;
	logic [FIELD_W-1:0] report_pump1;
	logic [FIELD_W-1:0] report_pump2;
	logic               crc_match;

	modport source (
		output valid, kind, report_seq, report_pump1, report_pump2, crc_match,
		input  ready
	);
	modport sink (
		input  valid, kind, report_seq, report_pump1, report_pump2, crc_match,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/plm_result_if.sv
// Result channel interface: graded status words.
`default_nettype none

interface plm_result_if
	import plm_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [ST_W-1:0]    status;
	logic [AGE_W-1:0]   seq_age_s;
	logic [AGE_W-1:0]   pump1_age_s;
	logic [AGE_W-1:0]   pump2_age_s;
	logic [FIELD_W-1:0] held_seq;
	logic [FIELD_W-1:0] held_pump1;
	logic [FIELD_W-1:0] held_pump2;
	logic               both_changed_recent;

	modport source (
		output valid, status, seq_age_s, pump1_age_s, pump2_age_s,
		       held_seq, held_pump1, held_pump2, both_changed_recent,
		input  ready
	);
	modport sink (
		input  valid, status, seq_age_s, pump1_age_s, pump2_age_s,
		       held_seq, held_pump1, held_pump2, both_changed_recent,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/pump_link_activity_monitor.sv
// Top level of the pump link activity monitor.
// Watches a link that reports a sequence number and two pump event counts. Tick words
// advance a seconds counter; report words with a matching checksum update the held values
// and their change times; report and evaluate words each return one status word with the
// ages, held values and a flag for both pumps changing together. A word is registered on
// entry in the input stage register, then graded from there straight into the output
// register; one word is taken every cycle while the result channel does not stall, and the
// single update-and-grade step against the held state sets that rate. The user must write
// thresholds over APB only while the block is idle; the block itself does not enforce this.
`default_nettype none

module pump_link_activity_monitor
	import plm_pkg::*;
#(
	parameter int TIME_BITS  = 32,
	parameter int VALUE_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	plm_item_if.sink               item,
	plm_result_if.source           result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	plm_cfg_t    cfg;
	plm_item_t   item_s1;
	logic        item_valid_s1;
	plm_result_t res;
	plm_result_t res_q;
	logic        res_valid_q;
	logic        has_res, out_free, advance;

	plm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	plm_core #(
		.TIME_BITS  (TIME_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.go     (advance),
		.res    (res)
	);

	assign has_res  = (item_s1.kind == KIND_EVAL) || (item_s1.kind == KIND_REPORT);
	assign out_free = !res_valid_q || result.ready;
	assign advance  = item_valid_s1 && (!has_res || out_free);
	assign item.ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item.ready) begin
			item_valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.kind         <= item.kind;
			item_s1.report_seq   <= item.report_seq;
			item_s1.report_pump1 <= item.report_pump1;
			item_s1.report_pump2 <= item.report_pump2;
			item_s1.crc_match    <= item.crc_match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_q <= res;
		end
	end

	assign result.valid               = res_valid_q;
	assign result.status              = res_q.status;
	assign result.seq_age_s           = res_q.seq_age_s;
	assign result.pump1_age_s         = res_q.pump1_age_s;
	assign result.pump2_age_s         = res_q.pump2_age_s;
	assign result.held_seq            = res_q.held_seq;
	assign result.held_pump1          = res_q.held_pump1;
	assign result.held_pump2          = res_q.held_pump2;
	assign result.both_changed_recent = res_q.both_changed_recent;

endmodule

`default_nettype wire

FILE: rtl/core/plm_cfg.sv
// APB configuration registers for the thresholds and windows.
`default_nettype none

module plm_cfg
	import plm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output plm_cfg_t               cfg
);

	plm_cfg_t             cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[APB_AW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.recent_window_s    <= RST_RECENT_WINDOW;
			cfg_q.pump_idle_s        <= RST_PUMP_IDLE;
			cfg_q.pump_idle_long_s   <= RST_PUMP_IDLE_LNG;
			cfg_q.comms_lost_s       <= RST_COMMS_LOST;
			cfg_q.comms_lost_long_s  <= RST_COMMS_LOST_LNG;
			cfg_q.both_change_hold_s <= RST_BOTH_HOLD;
		end else if (wr_en) begin
			unique case (idx)
				REG_RECENT_WINDOW:  cfg_q.recent_window_s    <= pwdata[WIN_W-1:0];
				REG_PUMP_IDLE:      cfg_q.pump_idle_s        <= pwdata[LIM_W-1:0];
				REG_PUMP_IDLE_LNG:  cfg_q.pump_idle_long_s   <= pwdata[LIM_W-1:0];
				REG_COMMS_LOST:     cfg_q.comms_lost_s       <= pwdata[LIM_W-1:0];
				REG_COMMS_LOST_LNG: cfg_q.comms_lost_long_s  <= pwdata[LIM_W-1:0];
				REG_BOTH_HOLD:      cfg_q.both_change_hold_s <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RECENT_WINDOW:  prdata = APB_DW'(cfg_q.recent_window_s);
			REG_PUMP_IDLE:      prdata = APB_DW'(cfg_q.pump_idle_s);
			REG_PUMP_IDLE_LNG:  prdata = APB_DW'(cfg_q.pump_idle_long_s);
			REG_COMMS_LOST:     prdata = APB_DW'(cfg_q.comms_lost_s);
			REG_COMMS_LOST_LNG: prdata = APB_DW'(cfg_q.comms_lost_long_s);
			REG_BOTH_HOLD:      prdata = APB_DW'(cfg_q.both_change_hold_s);
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/plm_core.sv
// Seconds counter, held values, change times, ages and status grading.
`default_nettype none

module plm_core
	import plm_pkg::*;
#(
	parameter int TIME_BITS  = 32,
	parameter int VALUE_BITS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire plm_cfg_t  cfg,
	input  wire plm_item_t item,
	input  wire logic      go,
	output plm_result_t    res
);

	localparam int VW = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;
	localparam int AW = (TIME_BITS > AGE_W) ? TIME_BITS : AGE_W;
	localparam int CW = (TIME_BITS > LIM_W) ? TIME_BITS : LIM_W;

	logic [TIME_BITS-1:0]  seconds_q, seq_time_q, p1_time_q, p2_time_q, both_time_q;
	logic                  both_seen_q;
	logic [VALUE_BITS-1:0] seq_q, p1_q, p2_q;

	logic [VW-1:0]         rs_w, r1_w, r2_w;
	logic [VALUE_BITS-1:0] rs, r1, r2;
	logic                  upd, seq_chg, p1_chg, p2_chg, both_chg, both_seen_n;
	logic [TIME_BITS-1:0]  seq_age, p1_age, p2_age, both_age;
	logic [CW-1:0]         sa_c, p1a_c, p2a_c, ba_c;
	logic [VALUE_BITS-1:0] seq_n, p1_n, p2_n;
	logic [VW-1:0]         seq_o, p1_o, p2_o;
	logic [AW-1:0]         sa_o, p1a_o, p2a_o;
	logic [ST_W-1:0]       st;

	assign rs_w = VW'(item.report_seq);
	assign r1_w = VW'(item.report_pump1);
	assign r2_w = VW'(item.report_pump2);
	assign rs   = rs_w[VALUE_BITS-1:0];
	assign r1   = r1_w[VALUE_BITS-1:0];
	assign r2   = r2_w[VALUE_BITS-1:0];

	assign upd      = (item.kind == KIND_REPORT) && item.crc_match;
	assign seq_chg  = upd && (rs != seq_q);
	assign p1_chg   = upd && (r1 != p1_q);
	assign p2_chg   = upd && (r2 != p2_q);
	assign both_chg = p1_chg && p2_chg;
	assign both_seen_n = both_seen_q || both_chg;

	assign seq_n = seq_chg ? rs : seq_q;
	assign p1_n  = p1_chg ? r1 : p1_q;
	assign p2_n  = p2_chg ? r2 : p2_q;

	assign seq_age  = seq_chg  ? '0 : seconds_q - seq_time_q;
	assign p1_age   = p1_chg   ? '0 : seconds_q - p1_time_q;
	assign p2_age   = p2_chg   ? '0 : seconds_q - p2_time_q;
	assign both_age = both_chg ? '0 : seconds_q - both_time_q;

	assign sa_c  = CW'(seq_age);
	assign p1a_c = CW'(p1_age);
	assign p2a_c = CW'(p2_age);
	assign ba_c  = CW'(both_age);

	always_comb begin
		priority if (sa_c >= CW'(cfg.comms_lost_long_s)) begin
			st = ST_NO_COMMS_LONG;
		end else if (sa_c >= CW'(cfg.comms_lost_s)) begin
			st = ST_NO_COMMS;
		end else if (p1a_c >= CW'(cfg.pump_idle_long_s) &&
		             p2a_c >= CW'(cfg.pump_idle_long_s)) begin
			st = ST_BOTH_IDLE_LONG;
		end else if (p1a_c >= CW'(cfg.pump_idle_s) && p2a_c >= CW'(cfg.pump_idle_s)) begin
			st = ST_BOTH_IDLE;
		end else if (p1a_c >= CW'(cfg.pump_idle_s) || p2a_c >= CW'(cfg.pump_idle_s)) begin
			st = ST_ONE_IDLE;
		end else if (sa_c < CW'(cfg.recent_window_s)) begin
			st = ST_RECENT;
		end else begin
			st = ST_OK;
		end
	end

	assign seq_o = VW'(seq_n);
	assign p1_o  = VW'(p1_n);
	assign p2_o  = VW'(p2_n);
	assign sa_o  = AW'(seq_age);
	assign p1a_o = AW'(p1_age);
	assign p2a_o = AW'(p2_age);

	assign res.status              = st;
	assign res.seq_age_s           = sa_o[AGE_W-1:0];
	assign res.pump1_age_s         = p1a_o[AGE_W-1:0];
	assign res.pump2_age_s         = p2a_o[AGE_W-1:0];
	assign res.held_seq            = seq_o[FIELD_W-1:0];
	assign res.held_pump1          = p1_o[FIELD_W-1:0];
	assign res.held_pump2          = p2_o[FIELD_W-1:0];
	assign res.both_changed_recent = both_seen_n && (ba_c < CW'(cfg.both_change_hold_s));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seconds_q   <= '0;
			seq_time_q  <= '0;
			p1_time_q   <= '0;
			p2_time_q   <= '0;
			both_time_q <= '0;
			both_seen_q <= 1'b0;
			seq_q       <= '0;
			p1_q        <= '0;
			p2_q        <= '0;
		end else if (go) begin
			if (item.kind == KIND_TICK) begin
				seconds_q <= seconds_q + 1'b1;
			end
			if (seq_chg) begin
				seq_time_q <= seconds_q;
			end
			if (p1_chg) begin
				p1_time_q <= seconds_q;
			end
			if (p2_chg) begin
				p2_time_q <= seconds_q;
			end
			if (both_chg) begin
				both_time_q <= seconds_q;
			end
			both_seen_q <= both_seen_n;
			seq_q       <= seq_n;
			p1_q        <= p1_n;
			p2_q        <= p2_n;
		end
	end

endmodule

`default_nettype wire
